// File: hw/rtl/ibmf_pkg.sv
// ----------------------------------------------------------------------------
// IoU best-match finder package
// Widths, codes, shared types and the span helper used by the finder.
// ----------------------------------------------------------------------------
package ibmf_pkg;

  localparam int MAX_BOXES    = 64;
  localparam int COORD_BITS   = 14;
  localparam int IDX_W        = $clog2(MAX_BOXES);
  localparam int SLOT_W       = 6;
  localparam int CNT_W        = 7;
  localparam int THR_W        = 17;
  localparam int OUT_W        = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 17;
  localparam int SPAN_W       = COORD_BITS + 1;
  localparam int AREA_W       = 2 * COORD_BITS + 1;
  localparam int UNI_W        = AREA_W + 1;
  localparam int PROD_W       = AREA_W + UNI_W;
  localparam int THR_PROD_W   = THR_W + UNI_W;
  localparam int FRAC_BITS    = 16;
  localparam int DRAIN_CYCLES = 5;
  localparam int DRAIN_W      = 3;

  localparam logic [THR_W-1:0]        THR_RESET = THR_W'(19661);
  localparam logic signed [OUT_W-1:0] NO_MATCH  = {OUT_W{1'b1}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PREV_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESH = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } box_t;

  typedef struct packed {
    logic             start;
    logic             ent_vld;
    logic [IDX_W-1:0] ent_idx;
  } iou_ctrl_t;

  typedef struct packed {
    logic             no_match;
    logic [IDX_W-1:0] best_idx;
  } iou_stat_t;

  // inclusive extent, zero when inverted
  function automatic logic [SPAN_W-1:0] span(input coord_t lo, input coord_t hi);
    logic [SPAN_W:0] d;
    d = {{2{hi[COORD_BITS-1]}}, hi} - {{2{lo[COORD_BITS-1]}}, lo} + (SPAN_W+1)'(1);
    if (d[SPAN_W]) begin
      return '0;
    end
    return d[SPAN_W-1:0];
  endfunction

endpackage

// File: hw/rtl/ibmf_in_if.sv
// ----------------------------------------------------------------------------
// IoU finder request channel
// Valid/ready channel carrying box write and query requests.
// ----------------------------------------------------------------------------
interface ibmf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [ibmf_pkg::SLOT_W-1:0] slot;
  ibmf_pkg::coord_t            box_left;
  ibmf_pkg::coord_t            box_top;
  ibmf_pkg::coord_t            box_right;
  ibmf_pkg::coord_t            box_bottom;

  modport source (output valid, op, slot, box_left, box_top, box_right, box_bottom,
                  input ready);
  modport sink (input valid, op, slot, box_left, box_top, box_right, box_bottom,
                output ready);
endinterface

// File: hw/rtl/ibmf_out_if.sv
// ----------------------------------------------------------------------------
// IoU finder result channel
// Valid/ready channel carrying the matched slot of each query.
// ----------------------------------------------------------------------------
interface ibmf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ibmf_pkg::OUT_W-1:0] match_index;

  modport source (output valid, match_index, input ready);
  modport sink (input valid, match_index, output ready);
endinterface

// File: hw/rtl/ibmf_cfg_if.sv
// ----------------------------------------------------------------------------
// IoU finder configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ibmf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ibmf_pkg::CFG_IDX_W-1:0]  index;
  logic [ibmf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ibmf_cell.sv
// ----------------------------------------------------------------------------
// IoU finder table cell
// Holds one stored box; loads on a write, takes its neighbour's box on a shift.
// ----------------------------------------------------------------------------
module ibmf_cell (
  input  logic           clk,
  input  logic           shift,
  input  logic           wr_en,
  input  ibmf_pkg::box_t wr_box,
  input  ibmf_pkg::box_t nbr_box,
  output ibmf_pkg::box_t box
);

  ibmf_pkg::box_t box_r;

  always_ff @(posedge clk) begin
    priority if (wr_en) begin
      box_r <= wr_box;
    end else if (shift) begin
      box_r <= nbr_box;
    end else begin
      box_r <= box_r;
    end
  end

  assign box = box_r;

endmodule

// File: hw/rtl/ibmf_ring.sv
// ----------------------------------------------------------------------------
// IoU finder box ring
// Circular chain of cells. A full turn of MAX_BOXES shifts brings every box
// back to its own slot; cell 0 feeds the overlap unit.
// ----------------------------------------------------------------------------
module ibmf_ring (
  input  logic                       clk,
  input  logic                       shift,
  input  logic                       wr_en,
  input  logic [ibmf_pkg::IDX_W-1:0] wr_slot,
  input  ibmf_pkg::box_t             wr_box,
  output ibmf_pkg::box_t             head
);

  ibmf_pkg::box_t cell_box [ibmf_pkg::MAX_BOXES];

  for (genvar k = 0; k < ibmf_pkg::MAX_BOXES; k++) begin : g_cell
    ibmf_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .wr_en   (wr_en && (wr_slot == ibmf_pkg::IDX_W'(k))),
      .wr_box  (wr_box),
      .nbr_box (cell_box[(k + 1) % ibmf_pkg::MAX_BOXES]),
      .box     (cell_box[k])
    );
  end

  assign head = cell_box[0];

endmodule

// File: hw/rtl/ibmf_iou.sv
// ----------------------------------------------------------------------------
// IoU finder overlap unit
// Pipelined intersection/union per stored box, running best by
// cross-multiplication and the threshold product of the best.
// ----------------------------------------------------------------------------
module ibmf_iou (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ibmf_pkg::iou_ctrl_t        ctrl,
  input  ibmf_pkg::box_t             qbox,
  input  ibmf_pkg::box_t             pbox,
  input  logic [ibmf_pkg::THR_W-1:0] threshold,
  output ibmf_pkg::iou_stat_t        stat
);

  localparam int AW = ibmf_pkg::AREA_W;
  localparam int UW = ibmf_pkg::UNI_W;
  localparam int PW = ibmf_pkg::PROD_W;
  localparam int TW = ibmf_pkg::THR_PROD_W;

  logic [ibmf_pkg::SPAN_W-1:0] q_w, q_h, i_w, i_h, p_w, p_h;
  ibmf_pkg::coord_t            x_l, x_t, x_r, x_b;
  logic [AW-1:0]               qa_r;

  logic                        a_vld_r;
  logic [ibmf_pkg::IDX_W-1:0]  a_idx_r;
  logic [ibmf_pkg::SPAN_W-1:0] a_iw_r, a_ih_r, a_pw_r, a_ph_r;

  logic                        b_vld_r;
  logic [ibmf_pkg::IDX_W-1:0]  b_idx_r;
  logic [AW-1:0]               b_inter_r, b_parea_r;

  logic [UW-1:0]               uni;
  logic                        c_vld_r;
  logic [ibmf_pkg::IDX_W-1:0]  c_idx_r;
  logic [AW-1:0]               c_inter_r;
  logic [UW-1:0]               c_uni_r;

  logic [PW-1:0]               lhs, rhs;
  logic [ibmf_pkg::IDX_W-1:0]  best_idx_r;
  logic [AW-1:0]               best_i_r;
  logic [UW-1:0]               best_u_r;
  logic [TW-1:0]               thr_prod_r;

  assign q_w = ibmf_pkg::span(qbox.left, qbox.right);
  assign q_h = ibmf_pkg::span(qbox.top, qbox.bottom);
  assign x_l = (qbox.left > pbox.left) ? qbox.left : pbox.left;
  assign x_t = (qbox.top > pbox.top) ? qbox.top : pbox.top;
  assign x_r = (qbox.right < pbox.right) ? qbox.right : pbox.right;
  assign x_b = (qbox.bottom < pbox.bottom) ? qbox.bottom : pbox.bottom;
  assign i_w = ibmf_pkg::span(x_l, x_r);
  assign i_h = ibmf_pkg::span(x_t, x_b);
  assign p_w = ibmf_pkg::span(pbox.left, pbox.right);
  assign p_h = ibmf_pkg::span(pbox.top, pbox.bottom);

  always_ff @(posedge clk) begin
    qa_r <= AW'(AW'(q_w) * AW'(q_h));
    // stage A: extents
    a_idx_r <= ctrl.ent_idx;
    a_iw_r  <= i_w;
    a_ih_r  <= i_h;
    a_pw_r  <= p_w;
    a_ph_r  <= p_h;
    // stage B: areas
    b_idx_r   <= a_idx_r;
    b_inter_r <= AW'(AW'(a_iw_r) * AW'(a_ih_r));
    b_parea_r <= AW'(AW'(a_pw_r) * AW'(a_ph_r));
    // stage C: union
    c_idx_r <= b_idx_r;
    if (uni == '0) begin
      c_inter_r <= '0;
      c_uni_r   <= UW'(1);
    end else begin
      c_inter_r <= b_inter_r;
      c_uni_r   <= uni;
    end
  end

  assign uni = UW'(qa_r) + UW'(b_parea_r) - UW'(b_inter_r);

  assign lhs = PW'(c_inter_r) * PW'(best_u_r);
  assign rhs = PW'(best_i_r) * PW'(c_uni_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= 1'b0;
      b_vld_r    <= 1'b0;
      c_vld_r    <= 1'b0;
      best_idx_r <= '0;
      best_i_r   <= '0;
      best_u_r   <= UW'(1);
    end else begin
      a_vld_r <= ctrl.ent_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      priority if (ctrl.start) begin
        best_idx_r <= '0;
        best_i_r   <= '0;
        best_u_r   <= UW'(1);
      end else if (c_vld_r && (lhs > rhs)) begin
        best_idx_r <= c_idx_r;
        best_i_r   <= c_inter_r;
        best_u_r   <= c_uni_r;
      end else begin
        best_idx_r <= best_idx_r;
        best_i_r   <= best_i_r;
        best_u_r   <= best_u_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    thr_prod_r <= TW'(threshold) * TW'(best_u_r);
  end

  assign stat.no_match = thr_prod_r > (TW'(best_i_r) << ibmf_pkg::FRAC_BITS);
  assign stat.best_idx = best_idx_r;

endmodule

// File: hw/rtl/iou_best_match_finder.sv
// ----------------------------------------------------------------------------
// IoU best-match finder
// Stores previous boxes in a ring of cells and answers each query box with
// the first slot of greatest intersection-over-union, or -1 below threshold.
//
//  channel  dir  handshake    payload
//  in_if    in   valid/ready  op, slot, box_left, box_top, box_right, box_bottom
//  out_if   out  valid/ready  match_index (one per query request)
//  cfg_if   in   valid/ready  index, data (0 prev_count, 1 match_threshold)
//
// A write request leaves the block ready for the next request. A query request
// turns the ring once, one stored box per cycle into the overlap pipeline,
// then the pipeline drains and the threshold product settles.
// Reset clears control and configuration registers; the box table is not cleared.
// Requests are taken while a result waits, but a finished query whose result
// cannot be handed over holds the block and refuses requests until it can.
// ----------------------------------------------------------------------------
module iou_best_match_finder (
  input  logic        clk,
  input  logic        rst_n,
  ibmf_in_if.sink     in_if,
  ibmf_out_if.source  out_if,
  ibmf_cfg_if.sink    cfg_if
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [ibmf_pkg::IDX_W-1:0]          step_r, step_nxt;
  logic [ibmf_pkg::DRAIN_W-1:0]        drain_r, drain_nxt;
  logic [ibmf_pkg::CNT_W-1:0]          prev_count_r, n_sat;
  logic [ibmf_pkg::THR_W-1:0]          thr_r;
  ibmf_pkg::box_t                      q_box_r, in_box, ring_head;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [ibmf_pkg::OUT_W-1:0]   match_index_r, match_index_nxt;
  logic                                in_acc, wr_ok;
  ibmf_pkg::iou_ctrl_t                 ctrl;
  ibmf_pkg::iou_stat_t                 stat;

  assign in_box = '{left: in_if.box_left, top: in_if.box_top,
                    right: in_if.box_right, bottom: in_if.box_bottom};
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign wr_ok       = (ibmf_pkg::SLOT_W+1)'(in_if.slot) <
                       (ibmf_pkg::SLOT_W+1)'(ibmf_pkg::MAX_BOXES);

  assign n_sat = (prev_count_r > ibmf_pkg::CNT_W'(ibmf_pkg::MAX_BOXES)) ?
                 ibmf_pkg::CNT_W'(ibmf_pkg::MAX_BOXES) : prev_count_r;

  assign ctrl.start   = in_acc && (in_if.op == ibmf_pkg::OP_QUERY);
  assign ctrl.ent_vld = (state_r == S_RUN) && (ibmf_pkg::CNT_W'(step_r) < n_sat);
  assign ctrl.ent_idx = step_r;

  // configuration
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r <= '0;
      thr_r        <= ibmf_pkg::THR_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        ibmf_pkg::REG_PREV_COUNT:   prev_count_r <= cfg_if.data[ibmf_pkg::CNT_W-1:0];
        ibmf_pkg::REG_MATCH_THRESH: thr_r        <= cfg_if.data[ibmf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      q_box_r <= in_box;
    end
  end

  ibmf_ring u_ring (
    .clk     (clk),
    .shift   (state_r == S_RUN),
    .wr_en   (in_acc && (in_if.op == ibmf_pkg::OP_WRITE) && wr_ok),
    .wr_slot (in_if.slot[ibmf_pkg::IDX_W-1:0]),
    .wr_box  (in_box),
    .head    (ring_head)
  );

  ibmf_iou u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .qbox      (q_box_r),
    .pbox      (ring_head),
    .threshold (thr_r),
    .stat      (stat)
  );

  // sequencer and result register
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    drain_nxt       = drain_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    match_index_nxt = match_index_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctrl.start) begin
          state_nxt = S_RUN;
          step_nxt  = '0;
        end
      end
      S_RUN: begin
        step_nxt = step_r + ibmf_pkg::IDX_W'(1);
        if (step_r == ibmf_pkg::IDX_W'(ibmf_pkg::MAX_BOXES - 1)) begin
          state_nxt = S_DRAIN;
          drain_nxt = '0;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + ibmf_pkg::DRAIN_W'(1);
        if (drain_r == ibmf_pkg::DRAIN_W'(ibmf_pkg::DRAIN_CYCLES - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          match_index_nxt = stat.no_match ? ibmf_pkg::NO_MATCH :
                            $signed(ibmf_pkg::OUT_W'(stat.best_idx));
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_index_r <= match_index_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.match_index = match_index_r;

  a_query_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> (state_r == S_RUN) && (step_r == '0))
    else $error("query request did not start a ring turn");

  a_entries_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) |-> !ctrl.ent_vld)
    else $error("table entry issued outside a ring turn");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised without a finished query");

  a_ring_turn_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) && (drain_r == '0) |-> ($past(step_r) ==
      ibmf_pkg::IDX_W'(ibmf_pkg::MAX_BOXES - 1)))
    else $error("ring left before a full turn");

endmodule
